/* hw/rtl/lli_pkg.sv */
// Package for the line-line intersection block: widths, status codes and
// the payload types of both channels. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lli_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int FIELD_W        = 16;
   localparam int OUT_W          = 48;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_PARALLEL,
      STATUS_SATURATED
   } status_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] line_a_start_x;
      logic signed [FIELD_W-1:0] line_a_start_y;
      logic signed [FIELD_W-1:0] line_a_end_x;
      logic signed [FIELD_W-1:0] line_a_end_y;
      logic signed [FIELD_W-1:0] line_b_start_x;
      logic signed [FIELD_W-1:0] line_b_start_y;
      logic signed [FIELD_W-1:0] line_b_end_x;
      logic signed [FIELD_W-1:0] line_b_end_y;
      logic                      last_pair;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] cross_x;
      logic signed [OUT_W-1:0] cross_y;
      status_type              status;
      logic                    last_result;
   } rsp_word_type;

endpackage
`default_nettype wire

/* hw/rtl/lli_chan_if.sv */
// Valid/ready channel carrying one word of a type given at instantiation.
// Used with the word types of lli_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lli_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lli_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with a final
// round-half-up stage on the remainder. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module lli_divider #(
   parameter int NW    = 67,
   parameter int DW    = 35,
   parameter int TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire logic             in_valid,
   input  wire logic [NW-1:0]    in_num,
   input  wire logic [DW-1:0]    in_den,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [NW:0]           out_quot,
   output logic [TAG_W-1:0]      out_tag
);

   logic             valid_ff [0:NW];
   logic [NW-1:0]    num_ff   [0:NW];
   logic [NW-1:0]    quot_ff  [0:NW];
   logic [DW-1:0]    rem_ff   [0:NW];
   logic [DW-1:0]    den_ff   [0:NW];
   logic [TAG_W-1:0] tag_ff   [0:NW];

   logic             round_valid_ff;
   logic [NW:0]      round_quot_ff;
   logic [TAG_W-1:0] round_tag_ff;
   logic [NW:0]      round_quot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
      if (enable) begin
         num_ff[0]  <= in_num;
         quot_ff[0] <= '0;
         rem_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [DW:0]   trial;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] quot_in;

      always_comb begin
         trial   = {rem_ff[k], num_ff[k][NW-1]};
         take    = trial >= {1'b0, den_ff[k]};
         rem_in  = take ? DW'(trial - {1'b0, den_ff[k]}) : trial[DW-1:0];
         quot_in = {quot_ff[k][NW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (enable) begin
            num_ff[k+1]  <= num_ff[k] << 1;
            quot_ff[k+1] <= quot_in;
            rem_ff[k+1]  <= rem_in;
            den_ff[k+1]  <= den_ff[k];
            tag_ff[k+1]  <= tag_ff[k];
         end
      end
   end

   assign round_quot_in = (NW+1)'(quot_ff[NW])
                        + (NW+1)'({rem_ff[NW], 1'b0} >= {1'b0, den_ff[NW]});

   always_ff @(posedge clock) begin
      if (reset) begin
         round_valid_ff <= 1'b0;
      end else if (enable) begin
         round_valid_ff <= valid_ff[NW];
      end
      if (enable) begin
         round_quot_ff <= round_quot_in;
         round_tag_ff  <= tag_ff[NW];
      end
   end

   assign out_valid = round_valid_ff;
   assign out_quot  = round_quot_ff;
   assign out_tag   = round_tag_ff;

endmodule
`default_nettype wire

/* hw/rtl/line_line_intersection_core.sv */
// Top level of the line-line intersection block: input stages for the
// determinant and numerators, two lli_divider instances and the output register.
// Depends on lli_pkg, lli_chan_if and lli_divider.
//
// Usage: req_chan carries one word with two lines, each as two points, and a
// batch-end mark. rsp_chan returns one word per request with the crossing
// point in signed fixed point with FRAC_BITS fraction bits, a status and a copy
// of the mark. Parallel, coincident or degenerate lines give status parallel
// and a zero point. A point beyond the 48-bit range is clamped per coordinate
// and flagged as saturated.
// Throughput is one word per cycle while rsp_chan is not stalled.
// NW = 3*COORD_BITS + 3 + FRAC_BITS is the number of quotient bits; the
// divider resolves one bit per stage.
// All stages share one advance enable: while a result waits in the output
// register and rsp_chan.ready is low, the whole pipeline and req_chan.ready
// hold, and nothing is lost or repeated. Reset clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module line_line_intersection_core
   import lli_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   lli_chan_if.sink   req_chan,
   lli_chan_if.source rsp_chan
);

   localparam int CW   = COORD_BITS;
   localparam int XW   = (CW > FIELD_W) ? CW : FIELD_W;
   localparam int EW   = CW + 1;
   localparam int PW   = 2 * CW;
   localparam int CAW  = 2 * CW + 1;
   localparam int DW   = 2 * CW + 3;
   localparam int MW   = CAW + EW;
   localparam int NUMW = MW + 1;
   localparam int NW   = NUMW + FRAC_BITS;
   localparam int QW   = NW + 1;
   localparam int CMPW = (QW > OUT_W + 1) ? QW : OUT_W + 1;

   function automatic logic signed [CW-1:0] coord_of(input logic [FIELD_W-1:0] f);
      logic [XW-1:0] t;
      t = XW'(f);
      return t[CW-1:0];
   endfunction

   logic adv;
   logic signed [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

   logic                  v1_ff, last1_ff;
   logic signed [EW-1:0]  dxa1_ff, dya1_ff, dxb1_ff, dyb1_ff;
   logic signed [PW-1:0]  pa1_ff, pa2_ff, pb1_ff, pb2_ff;

   logic                  v2_ff, last2_ff;
   logic signed [EW-1:0]  dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff;
   logic signed [DW-1:0]  d2_ff, d2_in;
   logic signed [CAW-1:0] ca2_ff, cb2_ff;

   logic                  v3_ff, last3_ff;
   logic signed [DW-1:0]  d3_ff;
   logic signed [MW-1:0]  m1_ff, m2_ff, m3_ff, m4_ff;

   logic                  v4_ff, last4_ff;
   logic signed [DW-1:0]  d4_ff;
   logic signed [NUMW-1:0] numx4_ff, numy4_ff;

   logic [NUMW-1:0] magx, magy;
   logic [DW-1:0]   magd;
   logic            negx, negy, zero;

   logic            vx, vy;
   logic [QW-1:0]   qx, qy;
   logic [2:0]      tagx;
   logic            tagy;

   logic [CMPW-1:0] limx, limy, qxe, qye;
   logic            satx, saty;
   logic [OUT_W-1:0] valx, valy;

   logic         rsp_v_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;

   assign adv            = !rsp_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = rsp_v_ff;
   assign rsp_chan.word  = rsp_word_ff;

   always_comb begin
      ax1 = coord_of(req_chan.word.line_a_start_x);
      ay1 = coord_of(req_chan.word.line_a_start_y);
      ax2 = coord_of(req_chan.word.line_a_end_x);
      ay2 = coord_of(req_chan.word.line_a_end_y);
      bx1 = coord_of(req_chan.word.line_b_start_x);
      by1 = coord_of(req_chan.word.line_b_start_y);
      bx2 = coord_of(req_chan.word.line_b_end_x);
      by2 = coord_of(req_chan.word.line_b_end_y);
   end

   assign d2_in = DW'(dxa1_ff) * DW'(dyb1_ff) - DW'(dya1_ff) * DW'(dxb1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (adv) begin
         last1_ff <= req_chan.word.last_pair;
         dxa1_ff  <= EW'(ax1) - EW'(ax2);
         dya1_ff  <= EW'(ay1) - EW'(ay2);
         dxb1_ff  <= EW'(bx1) - EW'(bx2);
         dyb1_ff  <= EW'(by1) - EW'(by2);
         pa1_ff   <= PW'(ax1) * PW'(ay2);
         pa2_ff   <= PW'(ay1) * PW'(ax2);
         pb1_ff   <= PW'(bx1) * PW'(by2);
         pb2_ff   <= PW'(by1) * PW'(bx2);

         last2_ff <= last1_ff;
         dxa2_ff  <= dxa1_ff;
         dya2_ff  <= dya1_ff;
         dxb2_ff  <= dxb1_ff;
         dyb2_ff  <= dyb1_ff;
         d2_ff    <= d2_in;
         ca2_ff   <= CAW'(pa1_ff) - CAW'(pa2_ff);
         cb2_ff   <= CAW'(pb1_ff) - CAW'(pb2_ff);

         last3_ff <= last2_ff;
         d3_ff    <= d2_ff;
         m1_ff    <= MW'(ca2_ff) * MW'(dxb2_ff);
         m2_ff    <= MW'(dxa2_ff) * MW'(cb2_ff);
         m3_ff    <= MW'(ca2_ff) * MW'(dyb2_ff);
         m4_ff    <= MW'(dya2_ff) * MW'(cb2_ff);

         last4_ff <= last3_ff;
         d4_ff    <= d3_ff;
         numx4_ff <= NUMW'(m1_ff) - NUMW'(m2_ff);
         numy4_ff <= NUMW'(m3_ff) - NUMW'(m4_ff);
      end
   end

   always_comb begin
      magx = numx4_ff[NUMW-1] ? NUMW'(-numx4_ff) : NUMW'(numx4_ff);
      magy = numy4_ff[NUMW-1] ? NUMW'(-numy4_ff) : NUMW'(numy4_ff);
      magd = d4_ff[DW-1] ? DW'(-d4_ff) : DW'(d4_ff);
      negx = numx4_ff[NUMW-1] ^ d4_ff[DW-1];
      negy = numy4_ff[NUMW-1] ^ d4_ff[DW-1];
      zero = (d4_ff == '0);
   end

   lli_divider #(.NW(NW), .DW(DW), .TAG_W(3)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v4_ff),
      .in_num    (NW'(magx) << FRAC_BITS),
      .in_den    (magd),
      .in_tag    ({last4_ff, zero, negx}),
      .out_valid (vx),
      .out_quot  (qx),
      .out_tag   (tagx)
   );

   lli_divider #(.NW(NW), .DW(DW), .TAG_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v4_ff),
      .in_num    (NW'(magy) << FRAC_BITS),
      .in_den    (magd),
      .in_tag    (negy),
      .out_valid (vy),
      .out_quot  (qy),
      .out_tag   (tagy)
   );

   always_comb begin
      limx = tagx[0] ? (CMPW'(1) << (OUT_W - 1)) : ((CMPW'(1) << (OUT_W - 1)) - CMPW'(1));
      limy = tagy    ? (CMPW'(1) << (OUT_W - 1)) : ((CMPW'(1) << (OUT_W - 1)) - CMPW'(1));
      qxe  = CMPW'(qx);
      qye  = CMPW'(qy);
      satx = qxe > limx;
      saty = qye > limy;
      valx = satx ? limx[OUT_W-1:0] : qxe[OUT_W-1:0];
      valy = saty ? limy[OUT_W-1:0] : qye[OUT_W-1:0];
      rsp_word_in.last_result = tagx[2];
      if (tagx[1]) begin
         rsp_word_in.cross_x = '0;
         rsp_word_in.cross_y = '0;
         rsp_word_in.status  = STATUS_PARALLEL;
      end else begin
         rsp_word_in.cross_x = tagx[0] ? -valx : valx;
         rsp_word_in.cross_y = tagy ? -valy : valy;
         rsp_word_in.status  = (satx || saty) ? STATUS_SATURATED : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= vx;
      end
      if (adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      vx == vy)
      else $error("divider valid bits diverged");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_word_ff.status == STATUS_PARALLEL
         |-> rsp_word_ff.cross_x == '0 && rsp_word_ff.cross_y == '0)
      else $error("parallel result with nonzero point");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input accepted while the pipeline is stalled");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_chan.ready |=> rsp_v_ff && $stable(rsp_word_ff))
      else $error("stalled result changed");

endmodule
`default_nettype wire
